// ----- hdl/mipmap_box_downsample_top_defines.svh -----
// ---------------------------------------------------------------------------
// mipmap_box_downsample_top_defines.svh
// Assertion macros for the mip level box filter. The macros expand to
// nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef MIPMAP_BOX_DOWNSAMPLE_TOP_DEFINES_SVH
`define MIPMAP_BOX_DOWNSAMPLE_TOP_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define MBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define MBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define MBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hdl/mbd_pkg.sv -----
// ---------------------------------------------------------------------------
// mbd_pkg
// Shared types, register and format codes and the 2x2 channel average.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbd_pkg;

    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int FMT_W      = 2;
    localparam int PIX_W      = 64;
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_W      = 12;
    localparam int JOB_DEPTH  = 4;
    localparam int JOB_PTR_W  = 2;
    localparam int JOB_CNT_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT = 2'd2;

    localparam logic [FMT_W-1:0] FMT_RGBA8   = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGB8    = 2'd1;
    localparam logic [FMT_W-1:0] FMT_RGBA16  = 2'd2;
    localparam logic [FMT_W-1:0] FMT_RGB5551 = 2'd3;

    // Bit positions of the 5-bit channels in the 5551 layout.
    localparam int SH_R5 = 11;
    localparam int SH_G5 = 6;
    localparam int SH_B5 = 1;
    localparam logic [4:0] MASK5 = 5'h1F;

    // One pending average: upper left, upper right, lower left, lower right.
    typedef struct packed {
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] c;
        logic [PIX_W-1:0] d;
        logic             last;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

    function automatic logic [6:0] sum5(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                        input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] d,
                                        input int sh);
        sum5 = 7'(a[sh +: 5] & MASK5) + 7'(b[sh +: 5] & MASK5)
             + 7'(c[sh +: 5] & MASK5) + 7'(d[sh +: 5] & MASK5);
    endfunction

    function automatic logic [PIX_W-1:0] box4(input logic [FMT_W-1:0] fmt,
                                              input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c,
                                              input logic [PIX_W-1:0] d);
        logic [PIX_W-1:0] res;
        logic [17:0]      s16;
        logic [9:0]       s8;
        logic [6:0]       s5;
        int               i;
        res = '0;
        if (fmt == FMT_RGB5551) begin
            // Truncating average; the alpha bit stays 0.
            s5 = sum5(a, b, c, d, SH_R5);
            res[SH_R5 +: 5] = s5[6:2];
            s5 = sum5(a, b, c, d, SH_G5);
            res[SH_G5 +: 5] = s5[6:2];
            s5 = sum5(a, b, c, d, SH_B5);
            res[SH_B5 +: 5] = s5[6:2];
        end else if (fmt == FMT_RGBA16) begin
            for (i = 0; i < 4; i++) begin
                s16 = 18'(a[i*16 +: 16]) + 18'(b[i*16 +: 16]) + 18'(c[i*16 +: 16])
                    + 18'(d[i*16 +: 16]) + 18'd2;
                res[i*16 +: 16] = s16[17:2];
            end
        end else begin
            for (i = 0; i < 4; i++) begin
                s8 = 10'(a[i*8 +: 8]) + 10'(b[i*8 +: 8]) + 10'(c[i*8 +: 8])
                   + 10'(d[i*8 +: 8]) + 10'd2;
                if (fmt != FMT_RGB8 || i < 3) begin
                    res[i*8 +: 8] = s8[9:2];
                end
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/mipmap_box_downsample_top.sv -----
// ---------------------------------------------------------------------------
// mipmap_box_downsample_top
// Streaming 2x2 box filter that builds the next smaller mip level.
// ---------------------------------------------------------------------------
// Source pixels enter in raster order through push/full; a word is taken
// at a clock edge with push high and full low. Destination pixels leave in
// order through empty/pop with out_pixel and mip_done, the latter marking
// the last pixel of the destination level.
// While full is low the block takes one source pixel per clock. A result
// word that a source pixel completes passes the row RAM read register, the
// block queue and the output register, which stores the channel average.
// The user must write configuration (cfg_write/cfg_index/cfg_data) only
// while the block is idle; the block does not enforce it. Any valid register
// write restarts the source position. Reset clears the position, sets a
// 1x1 RGBA8 source and empties the queues. The upper row RAM needs no
// clearing pass. When the receiver stalls, the output register holds its
// word and a four-entry block queue keeps absorbing work; full rises once
// the queue and the block in flight fill it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "mipmap_box_downsample_top_defines.svh"

module mipmap_box_downsample_top
    import mbd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 push,
    input  wire logic [PIX_W-1:0]     pixel,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      empty,
    output logic [PIX_W-1:0]          out_pixel,
    output logic                      mip_done
);

    job_push_t            job_push;
    job_t                 job_head;
    logic [JOB_CNT_W-1:0] job_count;
    logic                 job_pop;
    logic [FMT_W-1:0]     fmt;

    mbd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .pixel     (pixel),
        .full      (full),
        .job_count (job_count),
        .job_push  (job_push),
        .fmt       (fmt)
    );

    mbd_job_fifo u_job_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (job_push),
        .pop   (job_pop),
        .head  (job_head),
        .count (job_count)
    );

    mbd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .fmt       (fmt),
        .head      (job_head),
        .job_count (job_count),
        .job_pop   (job_pop),
        .pop       (pop),
        .empty     (empty),
        .out_pixel (out_pixel),
        .mip_done  (mip_done)
    );

    // The credit check in the front must keep the queue from overflowing.
    `MBD_ASSERT_NOW(a_job_credit, clk, rst_n, 1'b1, ((JOB_CNT_W + 1)'(job_count) + (JOB_CNT_W + 1)'(job_push.valid)) <= (JOB_CNT_W + 1)'(JOB_DEPTH), "block queue credit exceeded")
    `MBD_ASSERT_NOW(a_job_no_underflow, clk, rst_n, job_pop, job_count != '0, "block queue popped while empty")
    `MBD_ASSERT_NEXT(a_load_shows_word, clk, rst_n, job_pop, !empty, "loaded result word not presented")

endmodule

`default_nettype wire

// ----- hdl/mbd_ram.sv -----
// ---------------------------------------------------------------------------
// mbd_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbd_ram #(
    parameter int WIDTH  = 128,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/mbd_front.sv -----
// ---------------------------------------------------------------------------
// mbd_front
// Accepts source pixels, tracks the raster position, keeps the upper row
// in a RAM of pixel pairs and hands each completed 2x2 block to the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbd_front
    import mbd_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 push,
    input  wire logic [PIX_W-1:0]     pixel,
    output logic                      full,
    input  wire logic [JOB_CNT_W-1:0] job_count,
    output job_push_t                 job_push,
    output logic [FMT_W-1:0]          fmt
);

    localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int EW         = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int PAIR_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int PAIR_AW    = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int HW         = CFG_W;

    logic [CFG_W-1:0] src_width_reg,  src_width_next;
    logic [CFG_W-1:0] src_height_reg, src_height_next;
    logic [FMT_W-1:0] fmt_reg,        fmt_next;
    logic [COL_W-1:0] col_reg,        col_next;
    logic [ROW_W-1:0] row_reg,        row_next;
    logic [PIX_W-1:0] held_reg,       held_next;
    logic [PIX_W-1:0] upper_reg,      upper_next;
    logic             s1_valid_reg,   s1_valid_next;
    logic             s1_ram_reg;
    job_t             s1_job_reg;

    logic [EW-1:0]    eff_w, w_even, x_inc;
    logic [HW-1:0]    eff_h, h_even, y_inc;
    logic             w_one, h_one, x_odd, y_odd;
    logic             last_col, last_row, cfg_hit, acc;
    logic             emit, use_ram, ram_we, ram_re, held_ld, upper_ld;
    job_t             new_job;
    logic [2*PIX_W-1:0] ram_rd;
    logic [PAIR_AW-1:0] pair_addr;

    // Sizes outside the supported range are clamped.
    always_comb
    begin
        if (src_width_reg == '0)
        begin
            eff_w = EW'(1);
        end
        else if (EW'(src_width_reg) > EW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW'(src_width_reg);
        end
        if (src_height_reg == '0)
        begin
            eff_h = HW'(1);
        end
        else if (src_height_reg > HW'(MAX_HEIGHT))
        begin
            eff_h = HW'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = src_height_reg;
        end
    end

    assign w_even    = {eff_w[EW-1:1], 1'b0};
    assign h_even    = {eff_h[HW-1:1], 1'b0};
    assign x_inc     = EW'(col_reg) + EW'(1);
    assign y_inc     = HW'(row_reg) + HW'(1);
    assign w_one     = (eff_w == EW'(1));
    assign h_one     = (eff_h == HW'(1));
    assign x_odd     = col_reg[0];
    assign y_odd     = row_reg[0];
    assign last_col  = (x_inc == w_even);
    assign last_row  = (y_inc == h_even);
    assign pair_addr = PAIR_AW'(col_reg >> 1);

    // Room is reserved for the block still waiting on the RAM read.
    assign full = ((JOB_CNT_W + 1)'(job_count) + (JOB_CNT_W + 1)'(s1_valid_reg))
                  >= (JOB_CNT_W + 1)'(JOB_DEPTH);
    assign acc  = push && !full;

    assign cfg_hit = cfg_write
                     && (cfg_index inside {CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_PIXEL_FORMAT});

    always_comb
    begin
        emit     = 1'b0;
        use_ram  = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        held_ld  = 1'b0;
        upper_ld = 1'b0;
        new_job.a    = pixel;
        new_job.b    = pixel;
        new_job.c    = pixel;
        new_job.d    = pixel;
        new_job.last = 1'b0;
        if (w_one && h_one)
        begin
            emit         = 1'b1;
            new_job.last = 1'b1;
        end
        else if (h_one)
        begin
            if (!x_odd)
            begin
                held_ld = 1'b1;
            end
            else
            begin
                emit         = 1'b1;
                new_job.a    = held_reg;
                new_job.c    = held_reg;
                new_job.last = last_col;
            end
        end
        else if (w_one)
        begin
            if (!y_odd)
            begin
                upper_ld = 1'b1;
            end
            else
            begin
                emit         = 1'b1;
                new_job.a    = upper_reg;
                new_job.b    = upper_reg;
                new_job.last = last_row;
            end
        end
        else
        begin
            // Even rows store column pairs; odd rows read the pair back.
            if (!x_odd)
            begin
                held_ld = 1'b1;
            end
            else if (!y_odd)
            begin
                ram_we = 1'b1;
            end
            else
            begin
                emit         = 1'b1;
                use_ram      = 1'b1;
                ram_re       = 1'b1;
                new_job.c    = held_reg;
                new_job.last = last_col && last_row;
            end
        end
    end

    always_comb
    begin
        src_width_next  = src_width_reg;
        src_height_next = src_height_reg;
        fmt_next        = fmt_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        held_next       = held_reg;
        upper_next      = upper_reg;
        s1_valid_next   = acc && emit;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:    src_width_next  = cfg_data;
                CFG_SRC_HEIGHT:   src_height_next = cfg_data;
                CFG_PIXEL_FORMAT: fmt_next        = cfg_data[FMT_W-1:0];
                default:          ;
            endcase
        end
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (acc)
        begin
            if (held_ld)
            begin
                held_next = pixel;
            end
            if (upper_ld)
            begin
                upper_next = pixel;
            end
            if (x_inc == eff_w)
            begin
                col_next = '0;
                row_next = (y_inc == eff_h) ? '0 : ROW_W'(y_inc);
            end
            else
            begin
                col_next = COL_W'(x_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= CFG_W'(1);
            src_height_reg <= CFG_W'(1);
            fmt_reg        <= FMT_RGBA8;
            col_reg        <= '0;
            row_reg        <= '0;
            held_reg       <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            src_width_reg  <= src_width_next;
            src_height_reg <= src_height_next;
            fmt_reg        <= fmt_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            held_reg       <= held_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        upper_reg <= upper_next;
        if (acc && emit)
        begin
            s1_job_reg <= new_job;
            s1_ram_reg <= use_ram;
        end
    end

    mbd_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (PAIR_DEPTH)
    ) u_row_ram (
        .clk     (clk),
        .wr_en   (acc && ram_we),
        .wr_addr (pair_addr),
        .wr_data ({pixel, held_reg}),
        .rd_en   (acc && ram_re),
        .rd_addr (pair_addr),
        .rd_data (ram_rd)
    );

    always_comb
    begin
        job_push.valid = s1_valid_reg;
        job_push.job   = s1_job_reg;
        if (s1_ram_reg)
        begin
            job_push.job.a = ram_rd[PIX_W-1:0];
            job_push.job.b = ram_rd[2*PIX_W-1:PIX_W];
        end
    end

    assign fmt = fmt_reg;

endmodule

`default_nettype wire

// ----- hdl/mbd_job_fifo.sv -----
// ---------------------------------------------------------------------------
// mbd_job_fifo
// Short queue of pending 2x2 blocks between the front and the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbd_job_fifo
    import mbd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire job_push_t            wr,
    input  wire logic                 pop,
    output job_t                      head,
    output logic [JOB_CNT_W-1:0]      count
);

    job_t                 entry_reg [JOB_DEPTH];
    logic [JOB_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [JOB_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [JOB_CNT_W-1:0] count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr.valid ? wr_ptr_reg + JOB_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + JOB_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + JOB_CNT_W'(wr.valid) - JOB_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            entry_reg[wr_ptr_reg] <= wr.job;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

// ----- hdl/mbd_back.sv -----
// ---------------------------------------------------------------------------
// mbd_back
// Averages the oldest queued block per channel and holds the result word
// in the output register until it is popped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbd_back
    import mbd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [FMT_W-1:0]     fmt,
    input  wire job_t                 head,
    input  wire logic [JOB_CNT_W-1:0] job_count,
    output logic                      job_pop,
    input  wire logic                 pop,
    output logic                      empty,
    output logic [PIX_W-1:0]          out_pixel,
    output logic                      mip_done
);

    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_pixel_reg;
    logic             mip_done_reg;

    // When the queue holds a block, a new word loads whenever the register is free or being emptied.
    assign job_pop = (job_count != '0) && (!out_valid_reg || pop);

    always_comb
    begin
        out_valid_next = job_pop || (out_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            out_pixel_reg <= box4(fmt, head.a, head.b, head.c, head.d);
            mip_done_reg  <= head.last;
        end
    end

    assign empty     = !out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign mip_done  = mip_done_reg;

endmodule

`default_nettype wire
